// ===== design/obpm_pkg.sv =====
// shared types, constants and helpers of the oscillator bank pwm mixer
package obpm_pkg;

	localparam int RATE_N  = 8;
	localparam int RIDX_W  = 3;
	localparam int RATE_W  = 16;
	localparam int STATE_W = 32;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = 48;
	localparam int DUTY_W  = 8;

	localparam int DUTY_OFFSET = 120;

	localparam logic signed [STATE_W-1:0] COS_INIT  = 32'sd1966080;
	localparam logic signed [STATE_W-1:0] STATE_MAX = 32'sh7fff_ffff;
	localparam logic signed [STATE_W-1:0] STATE_MIN = 32'sh8000_0000;

	localparam logic [RATE_W-1:0] RATE_RESET [RATE_N] = '{
		16'd655, 16'd649, 16'd636, 16'd616, 16'd649, 16'd642, 16'd629, 16'd609
	};

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL1 = 7'b0000010,
		ST_COS  = 7'b0000100,
		ST_MUL2 = 7'b0001000,
		ST_SIN  = 7'b0010000,
		ST_SCAN = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [STATE_W:0] v);
		logic signed [STATE_W-1:0] r;
		if (v[STATE_W] != v[STATE_W-1]) begin
			r = v[STATE_W] ? STATE_MIN : STATE_MAX;
		end else begin
			r = v[STATE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/obpm_mul.sv =====
// shared registered multiplier: signed state times unsigned rate
module obpm_mul (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [obpm_pkg::STATE_W-1:0]   a,
	input  logic        [obpm_pkg::RATE_W-1:0]    b,
	output logic signed [obpm_pkg::PROD_W-1:0]    p
);
	import obpm_pkg::*;

	logic signed [STATE_W+RATE_W:0] full;
	logic signed [PROD_W-1:0]       p_q;

	assign full = a * $signed({1'b0, b});

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= full[PROD_W-1:0];
		end
	end

	assign p = p_q;

endmodule

// ===== design/oscillator_bank_pwm_mixer.sv =====
// top level: bank of coupled-form sine/cosine oscillators mixed into four pwm duties
//
// usage:
// - rates are written through cfg_we / cfg_idx / cfg_wdata while the block is idle
// - one request on in_valid/in_ready carries advance; each request returns one
//   result of four duties on out_valid/out_ready
// - sine and cosine state live in two small synchronous memories, read ahead into a
//   register and written back after update; one shared multiplier does both products
// - with advance set an oscillator steps through ST_MUL1, ST_COS, ST_MUL2 and
//   ST_SIN (two products, two saturating adds); a new request is taken only
//   once the whole sweep is done
// - with advance clear the state is only scanned, not written back
// - reset loads the rate defaults and marks every memory entry unwritten, which
//   reads as sine 0 and cosine 30.0; no clearing pass is needed
// - the result sits in an output register: a new request is taken while it
//   waits, and a finished sweep stalls only if that register is still full
module oscillator_bank_pwm_mixer #(
	parameter int NUM_OSC = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [obpm_pkg::RIDX_W-1:0]     cfg_idx,
	input  logic [obpm_pkg::RATE_W-1:0]     cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            advance,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [obpm_pkg::DUTY_W-1:0]     duty_a,
	output logic [obpm_pkg::DUTY_W-1:0]     duty_b,
	output logic [obpm_pkg::DUTY_W-1:0]     duty_c,
	output logic [obpm_pkg::DUTY_W-1:0]     duty_d
);
	import obpm_pkg::*;

	localparam int IDX_W = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
	localparam int HALF  = NUM_OSC / 2;
	localparam int ACC_W = STATE_W + 2 + IDX_W;
	localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(DUTY_OFFSET * (1 << FRAC_W));

	state_t                      state_q;
	logic [IDX_W-1:0]            idx_q;
	logic [RATE_W-1:0]           rate_q [RATE_N];
	logic signed [STATE_W-1:0]   sin_mem [NUM_OSC];
	logic signed [STATE_W-1:0]   cos_mem [NUM_OSC];
	logic [NUM_OSC-1:0]          vld_q;
	logic signed [STATE_W-1:0]   rd_s_q;
	logic signed [STATE_W-1:0]   rd_c_q;
	logic                        rd_v_q;
	logic signed [STATE_W-1:0]   s_q;
	logic signed [STATE_W-1:0]   c_q;
	logic signed [ACC_W-1:0]     acc_q [4];
	logic                        out_valid_q;
	logic [DUTY_W-1:0]           duty_a_q;
	logic [DUTY_W-1:0]           duty_b_q;
	logic [DUTY_W-1:0]           duty_c_q;
	logic [DUTY_W-1:0]           duty_d_q;

	logic                        accept;
	logic                        is_last;
	logic                        rd_en;
	logic [IDX_W-1:0]            rd_addr;
	logic signed [STATE_W-1:0]   s_rd;
	logic signed [STATE_W-1:0]   c_rd;
	logic [RATE_W-1:0]           rate_sel;
	logic                        mul_en;
	logic signed [STATE_W-1:0]   mul_a;
	logic signed [PROD_W-1:0]    prod;
	logic signed [STATE_W-1:0]   prod_hi;
	logic signed [STATE_W-1:0]   c_new;
	logic signed [STATE_W-1:0]   s_new;
	logic signed [STATE_W-1:0]   acc_s_in;
	logic signed [STATE_W-1:0]   acc_c_in;
	logic                        acc_en;
	logic                        lo_half;
	logic                        out_load;

	function automatic logic [DUTY_W-1:0] to_duty(input logic signed [ACC_W-1:0] a);
		logic [DUTY_W-1:0] r;
		if (a < 0) begin
			r = '0;
		end else if (a[ACC_W-1:FRAC_W+DUTY_W] != '0) begin
			r = '1;
		end else begin
			r = a[FRAC_W+DUTY_W-1:FRAC_W];
		end
		return r;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_last   = (idx_q == IDX_W'(NUM_OSC - 1));
	assign rd_en     = accept || (((state_q == ST_SIN) || (state_q == ST_SCAN)) && !is_last);
	assign rd_addr   = accept ? '0 : idx_q + 1'b1;
	assign s_rd      = rd_v_q ? rd_s_q : '0;
	assign c_rd      = rd_v_q ? rd_c_q : COS_INIT;
	assign rate_sel  = rate_q[RIDX_W'(idx_q)];
	assign mul_en    = (state_q == ST_MUL1) || (state_q == ST_MUL2);
	assign mul_a     = (state_q == ST_MUL1) ? s_rd : c_q;
	assign prod_hi   = prod[PROD_W-1:FRAC_W];
	assign c_new     = sat_state({c_q[STATE_W-1], c_q} - {prod_hi[STATE_W-1], prod_hi});
	assign s_new     = sat_state({s_q[STATE_W-1], s_q} + {prod_hi[STATE_W-1], prod_hi});
	assign acc_en    = (state_q == ST_SIN) || (state_q == ST_SCAN);
	assign acc_s_in  = (state_q == ST_SIN) ? s_new : s_rd;
	assign acc_c_in  = (state_q == ST_SIN) ? c_q : c_rd;
	assign lo_half   = (int'(idx_q) < HALF);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	obpm_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (rate_sel),
		.p   (prod)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s_q <= sin_mem[rd_addr];
			rd_c_q <= cos_mem[rd_addr];
			rd_v_q <= vld_q[rd_addr];
		end
		if (state_q == ST_SIN) begin
			sin_mem[idx_q] <= s_new;
			cos_mem[idx_q] <= c_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL1) begin
			s_q <= s_rd;
			c_q <= c_rd;
		end else if (state_q == ST_COS) begin
			c_q <= c_new;
		end
		if (accept) begin
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= ACC_INIT;
			end
		end else if (acc_en) begin
			if (lo_half) begin
				acc_q[0] <= acc_q[0] + ACC_W'(acc_s_in);
				acc_q[1] <= acc_q[1] + ACC_W'(acc_c_in);
			end else begin
				acc_q[2] <= acc_q[2] + ACC_W'(acc_s_in);
				acc_q[3] <= acc_q[3] + ACC_W'(acc_c_in);
			end
		end
		if (out_load) begin
			duty_a_q <= to_duty(acc_q[0]);
			duty_b_q <= to_duty(acc_q[1]);
			duty_c_q <= to_duty(acc_q[2]);
			duty_d_q <= to_duty(acc_q[3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RATE_N; i++) begin
				rate_q[i] <= RATE_RESET[i];
			end
		end else if (cfg_we) begin
			rate_q[cfg_idx] <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= advance ? ST_MUL1 : ST_SCAN;
					end
				end
				ST_MUL1: state_q <= ST_COS;
				ST_COS:  state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_SIN;
				ST_SIN: begin
					vld_q[idx_q] <= 1'b1;
					if (is_last) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_MUL1;
					end
				end
				ST_SCAN: begin
					if (is_last) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign duty_a    = duty_a_q;
	assign duty_b    = duty_b_q;
	assign duty_c    = duty_c_q;
	assign duty_d    = duty_d_q;

endmodule

// ===== design/obpm_checker.sv =====
// port-level assertions for the oscillator bank pwm mixer, bound to the top level
module obpm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] duty_a,
	input logic [7:0] duty_b,
	input logic [7:0] duty_c,
	input logic [7:0] duty_d
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(duty_a) && $stable(duty_b) && $stable(duty_c) && $stable(duty_d))
		else $error("result changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request taken while a sweep runs");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown before the sweep finished");

endmodule

bind oscillator_bank_pwm_mixer obpm_checker u_obpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.duty_a    (duty_a),
	.duty_b    (duty_b),
	.duty_c    (duty_c),
	.duty_d    (duty_d)
);
